// ===== hdl/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assert a property, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/ohg_pkg.sv =====
// ----------------------------------------------------------------------------
// ohg_pkg
// shared types and constants of the orientation hinge gradient engine
// ----------------------------------------------------------------------------
package ohg_pkg;

  localparam int MAX_POINTS = 128;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_APPLY = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [0:0] REG_MARGIN = 1'b0;
  localparam logic [0:0] REG_COUNT  = 1'b1;

  localparam logic [40:0] MARGIN_RESET = 41'd1099512;
  localparam logic [7:0]  COUNT_RESET  = 8'd128;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // multiplier request: signed operands, shift select
  typedef enum logic [1:0] {SH_20, SH_30, SH_40} shift_t;

  typedef struct packed {
    logic                start;
    logic signed [63:0]  op_a;
    logic signed [63:0]  op_b;
    shift_t              sh;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic signed [63:0]  result;
  } mul_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
    else sat_add = s[63:0];
  endfunction

endpackage

// ===== hdl/ohg_mul.sv =====
// ----------------------------------------------------------------------------
// ohg_mul
// shared signed multiplier, 32x32 partial products over several cycles,
// rounding half away from zero and saturating to signed 64 bits
// ----------------------------------------------------------------------------
module ohg_mul (
  input  logic             clk,
  input  logic             rst,
  input  ohg_pkg::mul_req_t req,
  output ohg_pkg::mul_rsp_t rsp
);
  import ohg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_P3, S_FIN} st_t;

  st_t          st;
  logic         neg;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [127:0] acc;
  shift_t       sh;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  prod;
  logic [127:0] rounded;
  logic [127:0] q;
  logic [63:0]  lim;
  logic [63:0]  mag_q;
  logic [63:0]  res;

  always_comb begin
    unique case (st)
      S_P0:    begin pa = ua[31:0];  pb = ub[31:0];  end
      S_P1:    begin pa = ua[31:0];  pb = ub[63:32]; end
      S_P2:    begin pa = ua[63:32]; pb = ub[31:0];  end
      default: begin pa = ua[63:32]; pb = ub[63:32]; end
    endcase
    prod = {32'd0, pa} * {32'd0, pb};
  end

  always_comb begin
    case (sh)
      SH_20:   begin rounded = acc + (128'd1 << 19); q = rounded >> 20; end
      SH_30:   begin rounded = acc + (128'd1 << 29); q = rounded >> 30; end
      default: begin rounded = acc + (128'd1 << 39); q = rounded >> 40; end
    endcase
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    mag_q = (q[127:64] != 64'd0 || q[63:0] > lim) ? lim : q[63:0];
    res = neg ? (64'd0 - mag_q) : mag_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (st)
        S_IDLE: if (req.start) begin
          neg <= req.op_a[63] != req.op_b[63];
          ua  <= req.op_a[63] ? 64'd0 - req.op_a : req.op_a;
          ub  <= req.op_b[63] ? 64'd0 - req.op_b : req.op_b;
          sh  <= req.sh;
          acc <= 128'd0;
          st  <= S_P0;
        end
        S_P0: begin acc <= acc + {64'd0, prod}; st <= S_P1; end
        S_P1: begin acc <= acc + {32'd0, prod, 32'd0}; st <= S_P2; end
        S_P2: begin acc <= acc + {32'd0, prod, 32'd0}; st <= S_P3; end
        S_P3: begin acc <= acc + {prod, 64'd0}; st <= S_FIN; end
        S_FIN: begin
          rsp.result <= res;
          rsp.done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_done_after_fin, clk, rst, (st == S_FIN) |=> rsp.done, "mul done missing")
  `ASSERT_CLK(a_no_start_busy, clk, rst, rsp.done |-> $past(st == S_FIN), "stray mul done")
endmodule

// ===== hdl/ohg_mem.sv =====
// ----------------------------------------------------------------------------
// ohg_mem
// point store: coordinate and gradient memories, one access a cycle,
// registered read, per-point valid bits for the gradient reset value
// ----------------------------------------------------------------------------
module ohg_mem (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            coord_we,
  input  logic [ohg_pkg::IDX_W-1:0]       coord_addr,
  input  logic signed [31:0]              coord_wx,
  input  logic signed [31:0]              coord_wy,
  output logic signed [31:0]              coord_rx,
  output logic signed [31:0]              coord_ry,
  input  logic                            grad_we,
  input  logic                            grad_clr,
  input  logic [ohg_pkg::IDX_W-1:0]       grad_addr,
  input  logic signed [63:0]              grad_wx,
  input  logic signed [63:0]              grad_wy,
  output logic signed [63:0]              grad_rx,
  output logic signed [63:0]              grad_ry
);
  import ohg_pkg::*;

  logic signed [31:0]   cx [MAX_POINTS];
  logic signed [31:0]   cy [MAX_POINTS];
  logic signed [63:0]   gx [MAX_POINTS];
  logic signed [63:0]   gy [MAX_POINTS];
  logic [MAX_POINTS-1:0] gvalid;
  logic signed [63:0]   gx_q;
  logic signed [63:0]   gy_q;
  logic                 gv_q;

  always_ff @(posedge clk) begin
    if (coord_we) begin
      cx[coord_addr] <= coord_wx;
      cy[coord_addr] <= coord_wy;
    end
    coord_rx <= cx[coord_addr];
    coord_ry <= cy[coord_addr];
  end

  always_ff @(posedge clk) begin
    if (grad_we) begin
      gx[grad_addr] <= grad_wx;
      gy[grad_addr] <= grad_wy;
    end
    gx_q <= gx[grad_addr];
    gy_q <= gy[grad_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
      gv_q <= 1'b0;
    end else begin
      gv_q <= gvalid[grad_addr];
      if (grad_clr) gvalid[grad_addr] <= 1'b0;
      else if (grad_we) gvalid[grad_addr] <= 1'b1;
    end
  end

  assign grad_rx = gv_q ? gx_q : 64'sd0;
  assign grad_ry = gv_q ? gy_q : 64'sd0;
endmodule

// ===== hdl/orientation_hinge_gradient_top.sv =====
// ----------------------------------------------------------------------------
// orientation_hinge_gradient_top
// orientation constraint engine with squared hinge loss and gradients
// ----------------------------------------------------------------------------
// A command beat is taken when s_tvalid and s_tready are high. The block then
// works on it alone and drops s_tready until its result beat has been taken.
// m_tvalid rises from the output state for a load, a clear, a rejected
// command, a gradient read, a constraint whose hinge is not positive (which
// stops after the determinant and hinge) and a full constraint. Once the
// result beat is taken the block returns to idle and raises s_tready again.
// A full constraint reads the three points one a cycle, then runs nine
// multiplies one after another on a single shared 32x32 partial-product
// multiplier (each through operand capture, four partial products, round and
// saturate, hand-back) and does three gradient read-modify-writes on the
// point store; the shared multiplier sets the time. The result stays in
// m_tdata until taken; there is no clearing pass, the gradient store resets
// through per-point valid bits.
module orientation_hinge_gradient_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [40:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // cmd[1:0], point_index[8:2], coord_x[40:9], coord_y[72:41],
  // point_a[79:73], point_b[86:80], point_c[93:87],
  // orientation_negative[94], zero fill to 96
  input  logic [95:0]   s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // status[0], gradient_x[64:1], gradient_y[128:65], total_loss[191:129],
  // violated_count[207:192]
  output logic [207:0]  m_tdata
);
  import ohg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_RD_A, S_RD_B, S_RD_C, S_CAP_C,
    S_MUL_GO, S_MUL_WAIT, S_POST,
    S_GR_RD, S_GR_WAIT, S_GR_ADD, S_GR_WR,
    S_READ_W, S_READ_CAP, S_OUT
  } st_t;

  st_t st;

  // config
  logic [40:0] margin;
  logic [7:0]  point_count;

  // command fields
  logic [1:0]  cmd;
  logic [6:0]  pidx;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic [6:0]  pa, pb, pc;
  logic        oneg;

  logic [7:0] usable;
  assign usable = (point_count < 8'(MAX_POINTS)) ? point_count : 8'(MAX_POINTS);

  // coordinates captured
  logic signed [31:0] xa, ya, xb, yb, xc, yc;
  logic signed [63:0] t1, det, h;
  logic signed [63:0] gacc_x;
  logic [3:0]         step;
  logic [1:0]         gpt;

  logic [62:0] loss_total;
  logic [15:0] viol_total;
  logic        status;
  logic signed [63:0] out_gx, out_gy;

  // memory port
  logic              coord_we, grad_we, grad_clr;
  logic [IDX_W-1:0]  coord_addr, grad_addr;
  logic signed [31:0] crx, cry;
  logic signed [63:0] grx, gry, gwx, gwy;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  ohg_mem u_mem (
    .clk(clk), .rst(rst),
    .coord_we(coord_we), .coord_addr(coord_addr),
    .coord_wx(in_x), .coord_wy(in_y),
    .coord_rx(crx), .coord_ry(cry),
    .grad_we(grad_we), .grad_clr(grad_clr), .grad_addr(grad_addr),
    .grad_wx(gwx), .grad_wy(gwy), .grad_rx(grx), .grad_ry(gry)
  );

  ohg_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  // operand selection for the multiply sequence
  logic signed [63:0] v;
  logic signed [63:0] op_a, op_b;
  shift_t             op_sh;
  logic [6:0]         gpt_idx;

  function automatic logic signed [63:0] dif(input logic signed [31:0] p,
                                             input logic signed [31:0] q);
    dif = 64'(p) - 64'(q);
  endfunction

  assign v = oneg ? (h <<< 1) : -(h <<< 1);

  always_comb begin
    op_sh = SH_30;
    op_a = v;
    case (step)
      4'd0: begin op_a = dif(xb, xa); op_b = dif(yc, ya); op_sh = SH_20; end
      4'd1: begin op_a = dif(yb, ya); op_b = dif(xc, xa); op_sh = SH_20; end
      4'd2: begin op_a = h; op_b = h; op_sh = SH_40; end
      4'd3: op_b = dif(yb, yc);
      4'd4: op_b = dif(xc, xb);
      4'd5: op_b = dif(yc, ya);
      4'd6: op_b = dif(xa, xc);
      4'd7: op_b = dif(ya, yb);
      default: op_b = dif(xb, xa);
    endcase
  end

  always_comb begin
    case (gpt)
      2'd0:    gpt_idx = pa;
      2'd1:    gpt_idx = pb;
      default: gpt_idx = pc;
    endcase
  end

  assign mreq.op_a = op_a;
  assign mreq.op_b = op_b;
  assign mreq.sh   = op_sh;
  assign mreq.start = (st == S_MUL_GO);

  always_comb begin
    coord_we = 1'b0;
    coord_addr = pidx[IDX_W-1:0];
    grad_we = 1'b0;
    grad_clr = 1'b0;
    grad_addr = pidx[IDX_W-1:0];
    gwx = sat_add(grx, gacc_x);
    gwy = sat_add(gry, mrsp.result);
    case (st)
      S_DEC: if (cmd == CMD_LOAD && {1'b0, pidx} < usable) begin
        coord_we = 1'b1;
        grad_clr = 1'b1;
      end
      S_RD_A: coord_addr = pa[IDX_W-1:0];
      S_RD_B: coord_addr = pb[IDX_W-1:0];
      S_RD_C: coord_addr = pc[IDX_W-1:0];
      S_GR_RD, S_GR_WAIT, S_GR_ADD: grad_addr = gpt_idx[IDX_W-1:0];
      S_GR_WR: begin
        grad_addr = gpt_idx[IDX_W-1:0];
        grad_we = 1'b1;
      end
      default: ;
    endcase
  end

  logic sel_bad;
  assign sel_bad = ({1'b0, pa} >= usable) || ({1'b0, pb} >= usable) ||
                   ({1'b0, pc} >= usable) || pa == pb || pa == pc || pb == pc;

  logic signed [63:0] d_val, h_next;
  assign d_val  = oneg ? -det : det;
  assign h_next = $signed({23'd0, margin}) - d_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      margin <= MARGIN_RESET;
      point_count <= COUNT_RESET;
      loss_total <= '0;
      viol_total <= '0;
      m_tvalid <= 1'b0;
      s_tready <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MARGIN: margin <= cfg_data;
          REG_COUNT:  point_count <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (st)
        S_IDLE: begin
          s_tready <= 1'b1;
          if (s_tvalid && s_tready) begin
            s_tready <= 1'b0;
            cmd  <= s_tdata[1:0];
            pidx <= s_tdata[8:2];
            in_x <= s_tdata[40:9];
            in_y <= s_tdata[72:41];
            pa   <= s_tdata[79:73];
            pb   <= s_tdata[86:80];
            pc   <= s_tdata[93:87];
            oneg <= s_tdata[94];
            out_gx <= '0;
            out_gy <= '0;
            st <= S_DEC;
          end
        end
        S_DEC: begin
          status <= 1'b0;
          unique case (cmd)
            CMD_LOAD: begin
              status <= ({1'b0, pidx} >= usable);
              st <= S_OUT;
            end
            CMD_APPLY: begin
              if (sel_bad) begin
                status <= 1'b1;
                st <= S_OUT;
              end else st <= S_RD_A;
            end
            CMD_READ: begin
              if ({1'b0, pidx} >= usable) begin
                status <= 1'b1;
                st <= S_OUT;
              end else st <= S_READ_W;
            end
            CMD_CLEAR: begin
              loss_total <= '0;
              viol_total <= '0;
              st <= S_OUT;
            end
            default: st <= S_OUT;
          endcase
        end
        S_READ_W: st <= S_READ_CAP;
        S_READ_CAP: begin
          out_gx <= grx;
          out_gy <= gry;
          st <= S_OUT;
        end
        S_RD_A: st <= S_RD_B;
        S_RD_B: begin xa <= crx; ya <= cry; st <= S_RD_C; end
        S_RD_C: begin xb <= crx; yb <= cry; st <= S_CAP_C; end
        S_CAP_C: begin
          xc <= crx; yc <= cry;
          step <= 4'd0;
          gpt <= 2'd0;
          st <= S_MUL_GO;
        end
        S_MUL_GO: st <= S_MUL_WAIT;
        S_MUL_WAIT: if (mrsp.done) begin
          case (step)
            4'd0: begin t1 <= mrsp.result; step <= 4'd1; st <= S_MUL_GO; end
            4'd1: begin
              det <= sat_add(t1, -mrsp.result);
              st <= S_POST;
            end
            4'd2: begin
              loss_total <= ({1'b0, loss_total} + {1'b0, mrsp.result[62:0]} >
                             {1'b0, 63'h7FFF_FFFF_FFFF_FFFF}) ?
                            63'h7FFF_FFFF_FFFF_FFFF :
                            loss_total + mrsp.result[62:0];
              step <= 4'd3;
              st <= S_MUL_GO;
            end
            4'd3, 4'd5, 4'd7: begin
              gacc_x <= mrsp.result;
              step <= step + 4'd1;
              st <= S_MUL_GO;
            end
            default: st <= S_GR_RD;
          endcase
        end
        S_POST: begin
          if (d_val <= 0 && viol_total != 16'hFFFF) viol_total <= viol_total + 16'd1;
          h <= h_next;
          if (h_next <= 0) st <= S_OUT;
          else begin
            step <= 4'd2;
            st <= S_MUL_GO;
          end
        end
        S_GR_RD: st <= S_GR_WAIT;
        S_GR_WAIT: st <= S_GR_ADD;
        S_GR_ADD: st <= S_GR_WR;
        S_GR_WR: begin
          if (gpt == 2'd2) st <= S_OUT;
          else begin
            gpt <= gpt + 2'd1;
            step <= step + 4'd1;
            st <= S_MUL_GO;
          end
        end
        S_OUT: begin
          if (!m_tvalid) m_tvalid <= 1'b1;
          else if (m_tready) begin
            m_tvalid <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {viol_total, loss_total, out_gy, out_gx, status};

  `include "assert_macros.svh"
  `ASSERT_CLK(a_busy_no_ready, clk, rst, (st != S_IDLE) |-> !s_tready, "ready while busy")
  `ASSERT_CLK(a_out_only_in_out, clk, rst, m_tvalid |-> (st == S_OUT), "result outside out state")
  `ASSERT_CLK(a_one_wr_at_once, clk, rst, !(coord_we && grad_we), "two store writes")
endmodule
